@@ hw/rtl/dq_pkg.sv @@
// shared types and constants of the double-ended queue
package dq_pkg;

  localparam int unsigned DepthDefault     = 64;
  localparam int unsigned DataWidthDefault = 32;
  localparam int unsigned CmdWidth         = 3;
  localparam int unsigned ValueWidth       = 32;
  localparam int unsigned StatusWidth      = 2;
  localparam int unsigned CountWidth       = 7;

  typedef enum logic [CmdWidth-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [CmdWidth-1:0]          cmd;
    logic signed [ValueWidth-1:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic signed [ValueWidth-1:0] popped_value;
    logic [StatusWidth-1:0]       status;
    logic [CountWidth-1:0]        entry_count;
    logic                         is_empty;
  } res_t;

  // command held for the cycle in which the store read data comes back
  typedef struct packed {
    logic                   valid;
    logic                   is_pop;
    logic [StatusWidth-1:0] status;
    logic [CountWidth-1:0]  entry_count;
    logic                   is_empty;
  } pend_t;

endpackage

@@ hw/rtl/dq_stream_if.sv @@
// valid/ready channel carrying one payload per transfer
interface dq_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

@@ hw/rtl/dq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module dq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/dq_ctrl.sv @@
// front/back index and count keeping, store addressing and result status
module dq_ctrl #(
  parameter int unsigned DEPTH = dq_pkg::DepthDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic [dq_pkg::CmdWidth-1:0]    cmd_i,
  output logic                           we_o,
  output logic [$clog2(DEPTH)-1:0]       waddr_o,
  output logic                           re_o,
  output logic [$clog2(DEPTH)-1:0]       raddr_o,
  output dq_pkg::pend_t                  pend_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  localparam logic StIdle = 1'b0;
  localparam logic StRead = 1'b1;

  logic          state_q, state_d;
  logic [AW-1:0] front_q, front_d;
  logic [AW-1:0] back_q, back_d;
  logic [CW-1:0] count_q, count_d;
  logic          full, empty;
  logic          we, re, is_pop;
  logic [StatusWidth-1:0] status;
  pend_t         pend_q, pend_d;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    return (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    return (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  assign full  = (count_q == CW'(DEPTH));
  assign empty = (count_q == '0);

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    count_d = count_q;
    we      = 1'b0;
    re      = 1'b0;
    is_pop  = 1'b0;
    waddr_o = back_q;
    raddr_o = front_q;
    status  = STATUS_OK;
    case (cmd_i)
      CMD_PUSH_FRONT: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          front_d = idx_prev(front_q);
          waddr_o = idx_prev(front_q);
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_PUSH_BACK: begin
        if (full) begin
          status = STATUS_FULL;
        end else begin
          waddr_o = back_q;
          back_d  = idx_next(back_q);
          we      = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          raddr_o = front_q;
          front_d = idx_next(front_q);
          re      = 1'b1;
          is_pop  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          status = STATUS_EMPTY;
        end else begin
          raddr_o = idx_prev(back_q);
          back_d  = idx_prev(back_q);
          re      = 1'b1;
          is_pop  = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      CMD_CLEAR: begin
        front_d = '0;
        back_d  = '0;
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  assign we_o = accept_i & we;
  assign re_o = accept_i & re;

  assign state_d = accept_i ? StRead : StIdle;

  always_comb begin
    pend_d             = pend_q;
    pend_d.valid       = (state_d == StRead);
    if (accept_i) begin
      pend_d.is_pop      = is_pop;
      pend_d.status      = status;
      pend_d.entry_count = CountWidth'(count_d);
      pend_d.is_empty    = (count_d == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      front_q <= '0;
      back_q  <= '0;
      count_q <= '0;
      pend_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (accept_i) begin
        front_q <= front_d;
        back_q  <= back_d;
        count_q <= count_d;
      end
    end
  end

  assign pend_o = pend_q;

  // count never exceeds the store depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("entry count above depth");

  // one command at a time: no transfer while a read is outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRead) |-> !accept_i)
    else $error("command taken during read cycle");

  // a refused push leaves the count unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && status == STATUS_FULL) |=> $stable(count_q))
    else $error("count changed on refused push");

endmodule

@@ hw/rtl/double_ended_queue_top.sv @@
// top level of the double-ended queue: handshakes, store and result register
// A deque of signed words kept in a DEPTH-entry synchronous ram with front and
// back indices and a count. Each command transfer on cmd_i (push front, push
// back, pop front, pop back, clear) yields exactly one result transfer on
// res_o with the popped value (zero unless a pop succeeded), a status (ok,
// pop from empty, push into full), the entry count after the command and an
// empty flag. A command passes through the transfer cycle, in which the
// indices and count update and the ram is written or read, and then the ram
// read cycle, after which the result lands in the output register. One
// command is in flight at a time, so no command is taken in the ram read
// cycle; the next command is taken while the result register still holds a
// result, provided that result transfers in the same cycle. Only the low
// DATA_WIDTH bits of a pushed value are kept and, for a DATA_WIDTH below 32,
// a popped value is sign-extended back from DATA_WIDTH bits. The store needs
// no clearing after reset: a pop only reads entries that a push wrote.
module double_ended_queue_top #(
  parameter int unsigned DEPTH      = dq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = dq_pkg::DataWidthDefault
) (
  input logic        clk_i,
  input logic        rst_ni,
  dq_stream_if.sink   cmd_i,
  dq_stream_if.source res_o
);
  import dq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);

  // handshake and control
  logic                  accept;
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] wdata, rdata;
  logic [ValueWidth-1:0] rd_wide;
  pend_t                 pend;

  // output register
  logic                  out_valid_q, out_valid_d;
  res_t                  out_data_q, out_data_d;

  // a command is taken only if the result register is free by the next cycle
  assign cmd_i.ready = !pend.valid && (!out_valid_q || res_o.ready);
  assign accept      = cmd_i.valid && cmd_i.ready;

  dq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd_i.data.cmd),
    .we_o     (we),
    .waddr_o  (waddr),
    .re_o     (re),
    .raddr_o  (raddr),
    .pend_o   (pend)
  );

  // width fitting between the 32-bit fields and the stored word
  if (DATA_WIDTH > ValueWidth) begin : g_wide
    assign wdata   = {{(DATA_WIDTH - ValueWidth){1'b0}}, cmd_i.data.item_value};
    assign rd_wide = rdata[ValueWidth-1:0];
  end else if (DATA_WIDTH == ValueWidth) begin : g_same
    assign wdata   = cmd_i.data.item_value;
    assign rd_wide = rdata;
  end else begin : g_narrow
    assign wdata   = cmd_i.data.item_value[DATA_WIDTH-1:0];
    // sign-extend the stored word back to full width
    assign rd_wide = {{(ValueWidth - DATA_WIDTH){rdata[DATA_WIDTH-1]}}, rdata};
  end

  dq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // result register: loaded when the read data is back, emptied on transfer
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (pend.valid) begin
      out_valid_d             = 1'b1;
      out_data_d.popped_value = pend.is_pop ? rd_wide : '0;
      out_data_d.status       = pend.status;
      out_data_d.entry_count  = pend.entry_count;
      out_data_d.is_empty     = pend.is_empty;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.data  = out_data_q;

  // the result register is always free when read data comes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend.valid |-> !out_valid_q)
    else $error("result register busy when read data returned");

  // every command transfer shows up as pending read data and then as a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##1 pend.valid ##1 out_valid_q)
    else $error("command transfer produced no result");

  // an error result never carries a popped value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_data_q.status != STATUS_OK) |-> (out_data_q.popped_value == '0))
    else $error("popped value on an error result");

endmodule
